// ===== rtl/lz4_frame_block_walker_unit_defines.svh =====
// ----------------------------------------------------------------------------
// lz4 frame block walker: assertion macros
// shared property forms for the port checks of the walker
// ----------------------------------------------------------------------------
`ifndef LZ4_FRAME_BLOCK_WALKER_UNIT_DEFINES_SVH
`define LZ4_FRAME_BLOCK_WALKER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define LZ4FBW_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("lz4fbw port check failed");

// next-cycle implication, disabled while in reset
`define LZ4FBW_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("lz4fbw port check failed");

`endif

// ===== rtl/lz4fbw_pkg.sv =====
// ----------------------------------------------------------------------------
// lz4 frame block walker package
// phase, kind and error codes, result layout and small helpers
// ----------------------------------------------------------------------------
package lz4fbw_pkg;

    localparam logic [31:0] FRAME_MAGIC = 32'h184D2204;
    localparam logic [31:0] SIZE_MASK   = 32'h7fffffff;
    localparam logic [31:0] RAW_BIT     = 32'h80000000;

    localparam int RESULT_BITS = 200;
    localparam int BYTE_BITS   = 8;
    localparam int KIND_BITS   = 2;
    localparam int SPAN_BITS   = 32;
    localparam int CAP_BITS    = 23;

    // frame walk phase
    typedef enum logic [2:0] {
        PH_HEAD = 3'd0,
        PH_SIZE = 3'd1,
        PH_SKIP = 3'd2,
        PH_DONE = 3'd3,
        PH_FAIL = 3'd4
    } phase_t;

    // result kind, carried on tuser
    typedef enum logic [1:0] {
        KIND_BLOCK  = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    // final status error codes
    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_SHORT     = 3'd1,
        ERR_MAGIC     = 3'd2,
        ERR_SIZE_ID   = 3'd3,
        ERR_DEPENDENT = 3'd4,
        ERR_TRUNCATED = 3'd5,
        ERR_NO_BLOCKS = 3'd6
    } err_t;

    // result item layout, lowest field in the lowest bits
    typedef struct packed {
        logic [3:0]          pad;
        logic                checksums_present;
        logic [CAP_BITS-1:0] max_block_bytes;
        logic [31:0]         max_span;
        logic [31:0]         block_count;
        logic                raw_block;
        logic [31:0]         block_span;
        logic [39:0]         block_offset;
        logic [31:0]         block_index;
        err_t                error_code;
    } result_t;

    // decoded block capacity, 1 << (2*id + 8)
    function automatic logic [CAP_BITS-1:0] block_capacity(input logic [2:0] id);
        logic [4:0] sh;
        sh = 5'({id, 1'b0}) + 5'd8;
        block_capacity = CAP_BITS'(1) << sh;
    endfunction

endpackage

// ===== rtl/lz4_frame_block_walker_unit.sv =====
// ----------------------------------------------------------------------------
// lz4 frame block walker
// an accepted byte reaches its result item through the input register, then the
//   result register; throughput one byte per cycle, set by the single state
//   update per byte; stalls only while the result register is held
// reset: rst_n clears the frame state and both valid flags at once
// ----------------------------------------------------------------------------
module lz4_frame_block_walker_unit #(
    parameter int OFFSET_BITS = 40,
    parameter int COUNT_BITS  = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [lz4fbw_pkg::BYTE_BITS-1:0]      s_tdata,  // data_byte
    input  logic                                  s_tlast,  // last_byte
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // error_code, block_index, block_offset, block_span, raw_block, block_count,
    // max_span, max_block_bytes, checksums_present, zero fill to 200 bits
    output logic [lz4fbw_pkg::RESULT_BITS-1:0]    m_tdata,
    output logic [lz4fbw_pkg::KIND_BITS-1:0]      m_tuser   // kind
);
    import lz4fbw_pkg::*;

    localparam int OB = OFFSET_BITS;
    localparam int CB = COUNT_BITS;

    // input register
    logic                 in_valid_reg, in_valid_next;
    logic [BYTE_BITS-1:0] in_byte_reg;
    logic                 in_last_reg;

    // frame state
    phase_t        phase_reg, phase_next;
    logic [OB-1:0] byte_offset_reg, byte_offset_next;
    logic [7:0]    flag_reg, flag_next;
    logic [2:0]    size_id_reg, size_id_next;
    logic [4:0]    header_end_reg, header_end_next;
    logic [31:0]   size_word_reg, size_word_next;
    logic [31:0]   skip_left_reg, skip_left_next;
    logic [CB-1:0] blocks_seen_reg, blocks_seen_next;
    logic [31:0]   widest_span_reg, widest_span_next;
    err_t          fault_reg, fault_next;

    // result register
    logic    out_valid_reg, out_valid_next;
    result_t result_reg, result_next;
    kind_t   kind_reg, kind_next;

    // datapath helpers
    logic          slot_free;
    logic          proc;
    logic [31:0]   sw_shift;
    logic [OB:0]   off_inc;
    logic          rec_hit;
    logic [31:0]   body;
    logic [31:0]   span;
    logic          emit;
    logic [OB-1:0] rec_off;
    logic [OB+39:0] rec_off_wide;
    logic [CB+31:0] index_wide;
    logic [CB+31:0] count_wide;

    // handshake
    assign slot_free = !out_valid_reg || m_tready;
    assign proc      = in_valid_reg && slot_free;
    assign s_tready  = !in_valid_reg || slot_free;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (proc)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // shared values for this byte
    assign sw_shift = {in_byte_reg, size_word_reg[31:8]};
    assign off_inc  = {1'b0, byte_offset_reg} + (OB + 1)'(1);
    assign body     = (sw_shift & SIZE_MASK) + (flag_reg[4] ? 32'd4 : 32'd0);
    assign span     = body + 32'd4;

    // next frame state
    always_comb
    begin
        phase_next       = phase_reg;
        byte_offset_next = byte_offset_reg;
        flag_next        = flag_reg;
        size_id_next     = size_id_reg;
        header_end_next  = header_end_reg;
        size_word_next   = size_word_reg;
        skip_left_next   = skip_left_reg;
        blocks_seen_next = blocks_seen_reg;
        widest_span_next = widest_span_reg;
        fault_next       = fault_reg;
        rec_hit          = 1'b0;

        unique case (phase_reg)
            PH_HEAD:
            begin
                if (byte_offset_reg < OB'(4))
                begin
                    size_word_next = sw_shift;
                    if (byte_offset_reg == OB'(3) && sw_shift != FRAME_MAGIC)
                    begin
                        fault_next = ERR_MAGIC;
                        phase_next = PH_FAIL;
                    end
                end
                else if (byte_offset_reg == OB'(4))
                begin
                    flag_next = in_byte_reg;
                end
                else if (byte_offset_reg == OB'(5))
                begin
                    size_id_next = in_byte_reg[6:4];
                    if (in_byte_reg[6:4] < 3'd4)
                    begin
                        fault_next = ERR_SIZE_ID;
                        phase_next = PH_FAIL;
                    end
                    else if (!flag_reg[5])
                    begin
                        fault_next = ERR_DEPENDENT;
                        phase_next = PH_FAIL;
                    end
                    else
                    begin
                        header_end_next = 5'd7 + (flag_reg[3] ? 5'd8 : 5'd0)
                                        + (flag_reg[0] ? 5'd4 : 5'd0);
                    end
                end
                // header done, first size word follows
                if (phase_next == PH_HEAD && byte_offset_reg >= OB'(5)
                    && off_inc >= (OB + 1)'(header_end_next))
                begin
                    phase_next     = PH_SIZE;
                    skip_left_next = 32'd4;
                    size_word_next = '0;
                end
            end
            PH_SIZE:
            begin
                size_word_next = sw_shift;
                skip_left_next = skip_left_reg - 32'd1;
                if (skip_left_next == 32'd0)
                begin
                    if (sw_shift == 32'd0)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        rec_hit = 1'b1;
                        if (span > widest_span_reg)
                        begin
                            widest_span_next = span;
                        end
                        if (blocks_seen_reg != {CB{1'b1}})
                        begin
                            blocks_seen_next = blocks_seen_reg + CB'(1);
                        end
                        if (body == 32'd0)
                        begin
                            phase_next     = PH_SIZE;
                            skip_left_next = 32'd4;
                            size_word_next = '0;
                        end
                        else
                        begin
                            phase_next     = PH_SKIP;
                            skip_left_next = body;
                        end
                    end
                end
            end
            PH_SKIP:
            begin
                skip_left_next = skip_left_reg - 32'd1;
                if (skip_left_next == 32'd0)
                begin
                    phase_next     = PH_SIZE;
                    skip_left_next = 32'd4;
                    size_word_next = '0;
                end
            end
            default:
            begin
            end
        endcase

        // saturating byte counter
        if (byte_offset_reg != {OB{1'b1}})
        begin
            byte_offset_next = byte_offset_reg + OB'(1);
        end

        // final byte returns to the start of a new file
        if (in_last_reg)
        begin
            phase_next       = PH_HEAD;
            byte_offset_next = '0;
            flag_next        = '0;
            size_id_next     = '0;
            header_end_next  = 5'd7;
            size_word_next   = '0;
            skip_left_next   = '0;
            blocks_seen_next = '0;
            widest_span_next = '0;
            fault_next       = ERR_NONE;
        end
    end

    // record and final status fields
    assign rec_off      = (byte_offset_reg >= OB'(3)) ? byte_offset_reg - OB'(3) : '0;
    assign rec_off_wide = {40'b0, rec_off};
    assign index_wide   = {32'b0, blocks_seen_reg};

    // counter after this byte, needed in the final status
    always_comb
    begin
        count_wide = {32'b0, blocks_seen_reg};
        if (rec_hit && blocks_seen_reg != {CB{1'b1}})
        begin
            count_wide = {32'b0, blocks_seen_reg + CB'(1)};
        end
    end

    // result item
    always_comb
    begin
        err_t code;
        logic done_phase;
        code        = ERR_NONE;
        done_phase  = 1'b0;
        result_next = '0;
        kind_next   = KIND_BLOCK;
        emit        = 1'b0;

        if (in_last_reg)
        begin
            emit = 1'b1;
            // phase after this byte, ignoring the final-byte clear
            done_phase = (phase_reg == PH_DONE)
                      || (phase_reg == PH_SIZE && skip_left_reg == 32'd1
                          && sw_shift == 32'd0);
            if (byte_offset_reg < OB'(18))
            begin
                code = ERR_SHORT;
            end
            else if (fault_reg != ERR_NONE)
            begin
                code = fault_reg;
            end
            else if (!done_phase)
            begin
                code = ERR_TRUNCATED;
            end
            else if (count_wide[CB-1:0] == '0)
            begin
                code = ERR_NO_BLOCKS;
            end

            if (code == ERR_NONE)
            begin
                kind_next                     = KIND_ACCEPT;
                result_next.block_count       = count_wide[31:0];
                result_next.max_span          = widest_span_reg;
                result_next.max_block_bytes   = block_capacity(size_id_reg);
                result_next.checksums_present = flag_reg[4];
            end
            else
            begin
                kind_next              = KIND_REJECT;
                result_next.error_code = code;
            end
        end
        else if (rec_hit)
        begin
            emit                     = 1'b1;
            kind_next                = KIND_BLOCK;
            result_next.block_index  = index_wide[31:0];
            result_next.block_offset = rec_off_wide[39:0];
            result_next.block_span   = span;
            result_next.raw_block    = sw_shift[31];
        end
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HEAD;
            byte_offset_reg <= '0;
            flag_reg        <= '0;
            size_id_reg     <= '0;
            header_end_reg  <= 5'd7;
            size_word_reg   <= '0;
            skip_left_reg   <= '0;
            blocks_seen_reg <= '0;
            widest_span_reg <= '0;
            fault_reg       <= ERR_NONE;
        end
        else if (proc)
        begin
            phase_reg       <= phase_next;
            byte_offset_reg <= byte_offset_next;
            flag_reg        <= flag_next;
            size_id_reg     <= size_id_next;
            header_end_reg  <= header_end_next;
            size_word_reg   <= size_word_next;
            skip_left_reg   <= skip_left_next;
            blocks_seen_reg <= blocks_seen_next;
            widest_span_reg <= widest_span_next;
            fault_reg       <= fault_next;
        end
    end

    // result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (slot_free)
        begin
            out_valid_next = proc && emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && emit)
        begin
            result_reg <= result_next;
            kind_reg   <= kind_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;
    assign m_tuser  = kind_reg;

endmodule

// ===== rtl/lz4fbw_checker.sv =====
// ----------------------------------------------------------------------------
// lz4 frame block walker port checker
// watches the result channel for consistent record and status items
// ----------------------------------------------------------------------------
`include "lz4_frame_block_walker_unit_defines.svh"

module lz4fbw_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [lz4fbw_pkg::RESULT_BITS-1:0]  m_tdata,
    input logic [lz4fbw_pkg::KIND_BITS-1:0]    m_tuser
);
    import lz4fbw_pkg::*;

    result_t r;
    logic    in_fire;
    logic    is_block;
    logic    is_accept;
    logic    is_reject;
    logic    hold_wait;
    logic    quiet;
    logic    block_ok;
    logic    cap_ok;
    logic    accept_ok;
    logic    reject_ok;

    assign r         = m_tdata;
    assign in_fire   = s_tvalid && s_tready;
    assign is_block  = m_tvalid && (m_tuser == KIND_BLOCK);
    assign is_accept = m_tvalid && (m_tuser == KIND_ACCEPT);
    assign is_reject = m_tvalid && (m_tuser == KIND_REJECT);
    assign hold_wait = m_tvalid && !m_tready;
    assign quiet     = !in_fire && !m_tvalid;

    // field checks per result kind
    assign block_ok  = (r.block_span >= 32'd4) && (r.error_code == ERR_NONE)
                    && (r.block_count == 32'd0);
    assign cap_ok    = (r.max_block_bytes == 23'h010000) || (r.max_block_bytes == 23'h040000)
                    || (r.max_block_bytes == 23'h100000) || (r.max_block_bytes == 23'h400000);
    assign accept_ok = (r.error_code == ERR_NONE) && (r.block_count != 32'd0) && cap_ok;
    assign reject_ok = (r.error_code != ERR_NONE) && (r.block_count == 32'd0)
                    && (r.max_span == 32'd0);

    // a held result keeps its payload
    `LZ4FBW_ASSERT_NEXT(a_hold, clk, rst_n, hold_wait, m_tvalid && $stable({m_tuser, m_tdata}))

    // a block record carries a span of at least the size word, no error code and no block count
    `LZ4FBW_ASSERT_IMPLY(a_block, clk, rst_n, is_block, block_ok)

    // an accepted frame has blocks and a capacity from the allowed ids
    `LZ4FBW_ASSERT_IMPLY(a_accept, clk, rst_n, is_accept, accept_ok)

    // a rejected frame names an error and carries no block count and no max span
    `LZ4FBW_ASSERT_IMPLY(a_reject, clk, rst_n, is_reject, reject_ok)

    // no result straight out of reset without an item taken
    `LZ4FBW_ASSERT_NEXT(a_no_spurious, clk, rst_n, quiet, !m_tvalid || $past(s_tvalid, 2))

endmodule

bind lz4_frame_block_walker_unit lz4fbw_checker u_lz4fbw_checker (.*);

// ===== tb/lz4_frame_block_walker_unit_tb.sv =====
// ----------------------------------------------------------------------------
// lz4 frame block walker testbench
// feeds whole frame files byte by byte (well-formed frames, broken headers,
// truncated files and noise) and checks every block record and final status
// against a cycle-free model of the walker kept inside the bench
// ----------------------------------------------------------------------------
module lz4_frame_block_walker_unit_tb;

    import lz4fbw_pkg::*;

    localparam logic [39:0] OFFSET_MAX = 40'hFF_FFFF_FFFF;
    localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;
    localparam int          BUSY_PCT   = 30;

    // one byte of a file as offered on the input stream
    typedef struct {
        logic [7:0] data;
        logic       last;
    } feed_item_t;

    // one walker output as the model works it out
    typedef struct {
        kind_t   kind;
        result_t fields;
    } walker_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [BYTE_BITS-1:0]   s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [RESULT_BITS-1:0] m_tdata;
    logic [KIND_BITS-1:0]   m_tuser;

    feed_item_t     byte_feed[$];
    walker_result_t expected_records[$];
    logic [7:0]     file_bytes[$];

    int  mismatch_count = 0;
    int  n_accepted     = 0;
    int  n_fed          = 0;
    int  hold_left      = 0;
    bit  hold_done      = 0;
    bit  in_taken       = 0;
    bit  calm;
    feed_item_t next_item;

    // walker model state
    logic [39:0] walk_offset;
    phase_t      walk_phase;
    logic [7:0]  walk_flags;
    logic [2:0]  walk_size_id;
    logic [4:0]  walk_hdr_end;
    logic [31:0] walk_word;
    logic [31:0] walk_skip;
    logic [31:0] walk_blocks;
    logic [31:0] walk_widest;
    err_t        walk_fault;

    lz4_frame_block_walker_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // no idling on either side for a stretch in the middle of the run
    assign calm = (n_accepted >= 600) && (n_accepted < 800);

    // ------------------------------------------------------------------------
    // walker model
    // ------------------------------------------------------------------------

    task automatic clear_walker();
        walk_offset  = '0;
        walk_phase   = PH_HEAD;
        walk_flags   = '0;
        walk_size_id = '0;
        walk_hdr_end = 5'd7;
        walk_word    = '0;
        walk_skip    = '0;
        walk_blocks  = '0;
        walk_widest  = '0;
        walk_fault   = ERR_NONE;
    endtask

    task automatic start_size_word();
        walk_phase = PH_SIZE;
        walk_skip  = 32'd4;
        walk_word  = '0;
    endtask

    // advance the model by one byte and queue the result it gives, if any
    task automatic walk_byte(input logic [7:0] b, input logic last);
        logic [39:0]    off;
        logic           csum;
        logic [31:0]    body;
        logic [31:0]    span;
        logic [31:0]    cap;
        err_t           code;
        walker_result_t res;
        bit             have;
        off               = walk_offset;
        csum              = walk_flags[4];
        have              = 0;
        res.kind          = KIND_BLOCK;
        res.fields        = '0;
        case (walk_phase)
            PH_HEAD:
            begin
                if (off < 4)
                begin
                    walk_word = {b, walk_word[31:8]};
                    if (off == 3 && walk_word != FRAME_MAGIC)
                    begin
                        walk_fault = ERR_MAGIC;
                        walk_phase = PH_FAIL;
                    end
                end
                else if (off == 4)
                    walk_flags = b;
                else if (off == 5)
                begin
                    walk_size_id = b[6:4];
                    if (b[6:4] < 3'd4)
                    begin
                        walk_fault = ERR_SIZE_ID;
                        walk_phase = PH_FAIL;
                    end
                    else if (!walk_flags[5])
                    begin
                        walk_fault = ERR_DEPENDENT;
                        walk_phase = PH_FAIL;
                    end
                    else
                        walk_hdr_end = 5'd7 + (walk_flags[3] ? 5'd8 : 5'd0)
                                     + (walk_flags[0] ? 5'd4 : 5'd0);
                end
                if (walk_phase == PH_HEAD && off >= 5 && {1'b0, off} + 41'd1 >= walk_hdr_end)
                    start_size_word();
            end
            PH_SIZE:
            begin
                walk_word = {b, walk_word[31:8]};
                walk_skip = walk_skip - 1;
                if (walk_skip == 0)
                begin
                    if (walk_word == 0)
                        walk_phase = PH_DONE;
                    else
                    begin
                        body = (walk_word & SIZE_MASK) + (csum ? 32'd4 : 32'd0);
                        span = body + 32'd4;
                        res.fields.block_index  = walk_blocks;
                        res.fields.block_offset = (off >= 3) ? off - 40'd3 : 40'd0;
                        res.fields.block_span   = span;
                        res.fields.raw_block    = (walk_word & RAW_BIT) != 0;
                        have = 1;
                        if (span > walk_widest)
                            walk_widest = span;
                        if (walk_blocks < COUNT_MAX)
                            walk_blocks = walk_blocks + 1;
                        if (body == 0)
                            start_size_word();
                        else
                        begin
                            walk_phase = PH_SKIP;
                            walk_skip  = body;
                        end
                    end
                end
            end
            PH_SKIP:
            begin
                walk_skip = walk_skip - 1;
                if (walk_skip == 0)
                    start_size_word();
            end
            default:
            begin
            end
        endcase

        if (walk_offset != OFFSET_MAX)
            walk_offset = walk_offset + 1;

        // final byte: the status replaces any block record
        if (last)
        begin
            res.fields = '0;
            if (off < 18)
                code = ERR_SHORT;
            else if (walk_fault != ERR_NONE)
                code = walk_fault;
            else if (walk_phase != PH_DONE)
                code = ERR_TRUNCATED;
            else if (walk_blocks == 0)
                code = ERR_NO_BLOCKS;
            else
                code = ERR_NONE;
            if (code == ERR_NONE)
            begin
                cap = 32'd1 << ((6'(walk_size_id) * 6'd2 + 6'd8) & 6'd31);
                res.kind                      = KIND_ACCEPT;
                res.fields.block_count        = walk_blocks;
                res.fields.max_span           = walk_widest;
                res.fields.max_block_bytes    = cap[CAP_BITS-1:0];
                res.fields.checksums_present  = csum;
            end
            else
            begin
                res.kind              = KIND_REJECT;
                res.fields.error_code = code;
            end
            have = 1;
            clear_walker();
        end

        if (have)
            expected_records.push_back(res);
    endtask

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    task automatic check_result(input logic [KIND_BITS-1:0] kind_got,
                                input result_t got);
        walker_result_t want;
        if (expected_records.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing expected, kind %0d", kind_got));
            return;
        end
        want = expected_records.pop_front();
        compare_field("kind", kind_got, want.kind);
        compare_field("error_code", got.error_code, want.fields.error_code);
        compare_field("block_index", got.block_index, want.fields.block_index);
        compare_field("block_offset", got.block_offset, want.fields.block_offset);
        compare_field("block_span", got.block_span, want.fields.block_span);
        compare_field("raw_block", got.raw_block, want.fields.raw_block);
        compare_field("block_count", got.block_count, want.fields.block_count);
        compare_field("max_span", got.max_span, want.fields.max_span);
        compare_field("max_block_bytes", got.max_block_bytes, want.fields.max_block_bytes);
        compare_field("checksums_present", got.checksums_present,
                      want.fields.checksums_present);
        compare_field("zero fill", got.pad, 64'd0);
    endtask

    // monitor: model update on each accepted byte, check on each result item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                walk_byte(s_tdata, s_tlast);
                in_taken = 1;
                n_accepted++;
            end
            if (m_tvalid && m_tready)
                check_result(m_tuser, result_t'(m_tdata));
        end
    end

    // ------------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------------

    // sender: offers the next byte once the current one is taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || in_taken)
            begin
                if (byte_feed.size() != 0 && (calm || $urandom_range(99) >= BUSY_PCT))
                begin
                    next_item = byte_feed.pop_front();
                    s_tdata  <= next_item.data;
                    s_tlast  <= next_item.last;
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
            in_taken = 0;
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!hold_done && n_accepted >= 400)
            begin
                hold_done = 1;
                hold_left = 250;
                m_tready <= 1'b0;
            end
            else
                m_tready <= calm || ($urandom_range(99) >= BUSY_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // file building
    // ------------------------------------------------------------------------

    task automatic put_byte(input logic [7:0] b);
        file_bytes.push_back(b);
    endtask

    task automatic put_word(input logic [31:0] w);
        put_byte(w[7:0]);
        put_byte(w[15:8]);
        put_byte(w[23:16]);
        put_byte(w[31:24]);
    endtask

    task automatic put_random(input int n);
        for (int i = 0; i < n; i++)
            put_byte(8'($urandom));
    endtask

    // magic, flg, bd, optional content size and dictionary id, header checksum
    task automatic put_header(input logic [31:0] magic, input logic [7:0] flg,
                              input logic [7:0] bd);
        put_word(magic);
        put_byte(flg);
        put_byte(bd);
        if (flg[3])
            put_random(8);
        if (flg[0])
            put_random(4);
        put_random(1);
    endtask

    // size word, data and block checksum when flg asks for one
    task automatic put_block(input logic [7:0] flg, input logic raw, input int len);
        put_word({raw, 31'(len)});
        put_random(len);
        if (flg[4])
            put_random(4);
    endtask

    // hands the file (cut short when asked) to the sender, last mark on its end
    task automatic send_file(input int cut);
        feed_item_t item;
        int         n;
        n = file_bytes.size();
        if (cut > 0 && cut < n)
            n = cut;
        for (int i = 0; i < n; i++)
        begin
            item.data = file_bytes[i];
            item.last = (i == n - 1);
            byte_feed.push_back(item);
        end
        n_fed += n;
        file_bytes.delete();
    endtask

    task automatic wait_idle();
        while (byte_feed.size() != 0 || s_tvalid || expected_records.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------

    initial
    begin
        int          r;
        int          nb;
        int          files;
        int          len;
        logic        raw;
        logic [7:0]  flg;
        logic [7:0]  bd;
        logic [31:0] magic;

        clear_walker();
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // smallest accepted frame, 19 bytes
        put_header(FRAME_MAGIC, 8'h60, 8'h40);
        put_block(8'h60, 1'b0, 4);
        put_word(32'd0);
        send_file(0);

        // one byte short of the minimum
        put_header(FRAME_MAGIC, 8'h60, 8'h40);
        put_block(8'h60, 1'b0, 3);
        put_word(32'd0);
        send_file(0);

        // single byte file
        put_byte(8'h04);
        send_file(0);

        // short file with a bad magic still reports short
        put_header(32'h0, 8'h00, 8'h00);
        send_file(0);

        // bad magic
        put_header(32'h184D2205, 8'h60, 8'h40);
        put_block(8'h60, 1'b0, 6);
        put_word(32'd0);
        send_file(0);

        // size id below range, then size id zero with high and low bd bits set
        put_header(FRAME_MAGIC, 8'h60, 8'h30);
        put_block(8'h60, 1'b0, 6);
        put_word(32'd0);
        send_file(0);
        put_header(FRAME_MAGIC, 8'h60, 8'h8F);
        put_block(8'h60, 1'b0, 6);
        put_word(32'd0);
        send_file(0);

        // block-dependent frame
        put_header(FRAME_MAGIC, 8'h40, 8'h70);
        put_block(8'h40, 1'b0, 6);
        put_word(32'd0);
        send_file(0);

        // every flg bit set, largest blocks, junk after the end mark
        put_header(FRAME_MAGIC, 8'hFF, 8'hFF);
        put_block(8'hFF, 1'b1, 3);
        put_block(8'hFF, 1'b0, 9);
        put_word(32'd0);
        put_random(4);
        send_file(0);

        // raw block with an empty body, followed by a normal one
        put_header(FRAME_MAGIC, 8'h60, 8'h50);
        put_word(RAW_BIT);
        put_block(8'h60, 1'b0, 2);
        put_word(32'd0);
        send_file(0);

        // no blocks before the end mark
        put_header(FRAME_MAGIC, 8'h69, 8'h50);
        put_word(32'd0);
        send_file(0);

        // no end mark
        put_header(FRAME_MAGIC, 8'h70, 8'h60);
        put_block(8'h70, 1'b0, 5);
        send_file(0);

        // widest possible span, then the file stops
        put_header(FRAME_MAGIC, 8'h70, 8'h60);
        put_word(32'hFFFF_FFFF);
        put_random(3);
        send_file(0);

        // size word completed by the final byte: record dropped
        put_header(FRAME_MAGIC, 8'h60, 8'h40);
        put_block(8'h60, 1'b0, 6);
        put_word(32'h0000_0010);
        send_file(0);

        wait_idle();

        // random files, mostly well-formed with random content
        files = 0;
        while (n_fed < 900)
        begin
            r   = $urandom_range(99);
            flg = 8'($urandom);
            flg[5] = 1'b1;
            bd  = {1'($urandom), 3'($urandom_range(4, 7)), 4'($urandom)};
            magic = FRAME_MAGIC;
            if (r >= 78 && r < 84)
            begin
                case ($urandom_range(2))
                    0: magic = magic ^ (32'd1 << $urandom_range(31));
                    1: bd[6:4] = 3'($urandom_range(3));
                    default: flg[5] = 1'b0;
                endcase
            end
            put_header(magic, flg, bd);
            if (r >= 84 && r < 90)
            begin
                // huge size word, file ends inside the block
                put_word($urandom);
                put_random($urandom_range(0, 6));
                send_file(0);
            end
            else if (r >= 90)
            begin
                // noise, possibly starting like a frame
                if ($urandom_range(1))
                    file_bytes.delete();
                put_random($urandom_range(1, 40));
                send_file(0);
            end
            else
            begin
                nb = $urandom_range(0, 4);
                for (int i = 0; i < nb; i++)
                begin
                    len = $urandom_range(0, 12);
                    raw = 1'($urandom);
                    if (len == 0 && !flg[4])
                        raw = $urandom_range(3) != 0 ? 1'b1 : raw;
                    if (len == 0 && !raw)
                        raw = 1'b1;
                    put_block(flg, raw, len);
                end
                put_word(32'd0);
                put_random($urandom_range(0, 2));
                if (r >= 70)
                    send_file($urandom_range(1, file_bytes.size()));
                else
                    send_file(0);
            end
            files++;
            // sender pauses until every result is in
            if (files % 10 == 0)
                wait_idle();
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (expected_records.size() != 0)
            report_mismatch($sformatf("%0d results never came", expected_records.size()));
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // run limit
    initial
    begin
        #3000000;
        $display("simulation failed");
        $finish;
    end

endmodule
